>>> rtl/kwsm_pkg.sv
package kwsm_pkg;

   localparam int DATA_W = 32;
   localparam int FIELD_W = 3;
   localparam int LIST_COUNT_W = 4;
   localparam int MAX_LISTS_DEFAULT = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIST_COUNT_W-1:0] LIST_COUNT_RESET = 4'd8;

   // register index, taken from paddr above the byte offset
   localparam logic REG_LIST_COUNT = 1'b0;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MERGE = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [FIELD_W-1:0] list;
      logic [FIELD_W-1:0] pos;
   } heap_entry_type;

   typedef struct packed {
      logic valid;
      logic signed [DATA_W-1:0] value;
      logic last;
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_WR,
      ST_HEAP_RD,
      ST_HEAP_LD,
      ST_SIFT_CHK,
      ST_SIFT_LEFT,
      ST_SIFT_RIGHT,
      ST_SIFT_DEC,
      ST_POP_RD,
      ST_POP_TOP,
      ST_POP_NEXT,
      ST_POP_LAST
   } state_type;

   // smaller value first, lower list on a tie
   function automatic logic goes_before(input heap_entry_type a, input heap_entry_type b);
      logic less;
      logic same;
      less = $signed(a.value) < $signed(b.value);
      same = a.value == b.value;
      return less || (same && (a.list < b.list));
   endfunction

endpackage

>>> rtl/k_way_sorted_merge.sv
// load request: accepted while idle, next request may follow in the next cycle
// merge request: seeds the heap with the first element of each list, then sifts each
//   inner node; each value then comes from the heap top, after any wait on the output
//   register; the heap memory gives one child read per cycle
// a request is accepted only when the previous merge has finished
// reset clears control state and sets list_count to 8; stored elements are kept
module k_way_sorted_merge #(
   parameter int MAX_LISTS = kwsm_pkg::MAX_LISTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [kwsm_pkg::FIELD_W-1:0]         req_list_index,
   input  logic [kwsm_pkg::FIELD_W-1:0]         req_position,
   input  logic signed [kwsm_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kwsm_pkg::DATA_W-1:0]   rsp_merged_value,
   output logic                                 rsp_last_flag,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [kwsm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [kwsm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [kwsm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   import kwsm_pkg::*;

   logic [LIST_COUNT_W-1:0] list_count_ff, list_count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_merged_value_ff;
   logic rsp_last_flag_ff;
   logic reg_idx;
   logic csr_write;
   logic out_free;
   emit_type emit;

   assign pready = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      list_count_in = list_count_ff;
      prdata = '0;
      unique case (reg_idx)
         REG_LIST_COUNT: begin
            prdata = CSR_DATA_W'(list_count_ff);
            if (csr_write) begin
               list_count_in = pwdata[LIST_COUNT_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   kwsm_ctrl #(
      .MAX_LISTS(MAX_LISTS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_list_index(req_list_index),
      .req_position(req_position),
      .req_value(req_value),
      .list_count(list_count_ff),
      .out_free(out_free),
      .emit(emit)
   );

   // output register parts the heap loop from the consumer
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         list_count_ff <= LIST_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         list_count_ff <= list_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_merged_value_ff <= emit.value;
         rsp_last_flag_ff <= emit.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_merged_value = rsp_merged_value_ff;
   assign rsp_last_flag = rsp_last_flag_ff;

endmodule

>>> rtl/kwsm_ram.sv
module kwsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/kwsm_ctrl.sv
module kwsm_ctrl #(
   parameter int MAX_LISTS = kwsm_pkg::MAX_LISTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [kwsm_pkg::FIELD_W-1:0]           req_list_index,
   input  logic [kwsm_pkg::FIELD_W-1:0]           req_position,
   input  logic signed [kwsm_pkg::DATA_W-1:0]     req_value,
   input  logic [kwsm_pkg::LIST_COUNT_W-1:0]      list_count,
   input  logic                                   out_free,
   output kwsm_pkg::emit_type                     emit
);

   import kwsm_pkg::*;

   localparam int HAW = $clog2(MAX_LISTS);
   localparam int EAW = $clog2(MAX_LISTS * MAX_LISTS);
   localparam int CW = $clog2(MAX_LISTS + 1);
   localparam int IW = CW + 1;
   localparam int MW = EAW + LIST_COUNT_W;
   localparam int HEAP_W = $bits(heap_entry_type);
   localparam logic [CW-1:0] K_MAX = CW'(MAX_LISTS);
   localparam logic [LIST_COUNT_W-1:0] MAX_LC = LIST_COUNT_W'(MAX_LISTS);

   function automatic logic [EAW-1:0] elem_addr(input logic [FIELD_W-1:0] list,
                                                input logic [LIST_COUNT_W-1:0] pos);
      logic [MW-1:0] full;
      full = MW'(list) * MW'(MAX_LISTS) + MW'(pos);
      return full[EAW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] size_ff, size_in;
   logic [HAW-1:0] seed_ff, seed_in;
   logic [HAW-1:0] node_ff, node_in;
   logic [HAW-1:0] hole_ff, hole_in;
   logic [HAW-1:0] best_idx_ff, best_idx_in;
   logic heapify_ff, heapify_in;
   heap_entry_type held_ff, held_in;
   heap_entry_type left_ff, left_in;
   heap_entry_type best_ff, best_in;

   logic elem_we;
   logic [EAW-1:0] elem_waddr;
   logic elem_re;
   logic [EAW-1:0] elem_raddr;
   logic [DATA_W-1:0] elem_rdata;

   logic heap_we;
   logic [HAW-1:0] heap_waddr;
   heap_entry_type heap_wdata;
   logic heap_re;
   logic [HAW-1:0] heap_raddr;
   logic [HEAP_W-1:0] heap_rdata_raw;
   heap_entry_type heap_rdata;

   logic [CW-1:0] k_sat;
   logic [IW-1:0] left_idx;
   logic [IW-1:0] right_idx;
   logic [IW-1:0] size_ext;
   logic [LIST_COUNT_W-1:0] top_pos_next;
   logic top_more;
   logic [CW-1:0] size_dec;
   logic [CW-1:0] half_m1;
   logic [HAW-1:0] seed_plus;
   logic seed_last;
   logic load_ok;
   logic sift_done;

   assign heap_rdata = heap_rdata_raw;
   assign k_sat = (list_count > MAX_LC) ? K_MAX : list_count[CW-1:0];
   assign left_idx = IW'({hole_ff, 1'b1});
   assign right_idx = IW'({hole_ff, 1'b0}) + IW'(2);
   assign size_ext = IW'(size_ff);
   assign top_pos_next = LIST_COUNT_W'(heap_rdata.pos) + LIST_COUNT_W'(1);
   assign top_more = top_pos_next < LIST_COUNT_W'(k_ff);
   assign size_dec = size_ff - CW'(1);
   assign half_m1 = (k_ff >> 1) - CW'(1);
   assign seed_plus = seed_ff + HAW'(1);
   assign seed_last = (IW'(seed_ff) + IW'(1)) == IW'(k_ff);
   assign load_ok = (LIST_COUNT_W'(req_list_index) < MAX_LC)
                    && (LIST_COUNT_W'(req_position) < MAX_LC);

   kwsm_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_LISTS * MAX_LISTS)
   ) u_elem_ram (
      .clock(clock),
      .we(elem_we),
      .waddr(elem_waddr),
      .wdata(req_value),
      .re(elem_re),
      .raddr(elem_raddr),
      .rdata(elem_rdata)
   );

   kwsm_ram #(
      .WIDTH(HEAP_W),
      .DEPTH(MAX_LISTS)
   ) u_heap_ram (
      .clock(clock),
      .we(heap_we),
      .waddr(heap_waddr),
      .wdata(heap_wdata),
      .re(heap_re),
      .raddr(heap_raddr),
      .rdata(heap_rdata_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         size_ff <= '0;
         seed_ff <= '0;
         node_ff <= '0;
         hole_ff <= '0;
         heapify_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         size_ff <= size_in;
         seed_ff <= seed_in;
         node_ff <= node_in;
         hole_ff <= hole_in;
         heapify_ff <= heapify_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      left_ff <= left_in;
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // the sequence of states keeps every heap read in a later cycle than
   // the write to the same entry, so no forwarding is needed
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      size_in = size_ff;
      seed_in = seed_ff;
      node_in = node_ff;
      hole_in = hole_ff;
      heapify_in = heapify_ff;
      held_in = held_ff;
      left_in = left_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      req_ready = 1'b0;
      elem_we = 1'b0;
      elem_waddr = elem_addr(req_list_index, LIST_COUNT_W'(req_position));
      elem_re = 1'b0;
      elem_raddr = '0;
      heap_we = 1'b0;
      heap_waddr = hole_ff;
      heap_wdata = held_ff;
      heap_re = 1'b0;
      heap_raddr = '0;
      emit.valid = 1'b0;
      emit.value = heap_rdata.value;
      emit.last = (size_ff == CW'(1)) && !top_more;
      sift_done = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  elem_we = load_ok;
               end else if (k_sat != '0) begin
                  k_in = k_sat;
                  size_in = k_sat;
                  seed_in = '0;
                  elem_re = 1'b1;
                  elem_raddr = elem_addr(FIELD_W'(0), LIST_COUNT_W'(0));
                  state_in = ST_SEED_WR;
               end
            end
         end
         ST_SEED_WR: begin
            heap_we = 1'b1;
            heap_waddr = seed_ff;
            heap_wdata.value = elem_rdata;
            heap_wdata.list = FIELD_W'(seed_ff);
            heap_wdata.pos = '0;
            if (seed_last) begin
               if (k_ff == CW'(1)) begin
                  state_in = ST_POP_RD;
               end else begin
                  node_in = half_m1[HAW-1:0];
                  heapify_in = 1'b1;
                  state_in = ST_HEAP_RD;
               end
            end else begin
               seed_in = seed_plus;
               elem_re = 1'b1;
               elem_raddr = elem_addr(FIELD_W'(seed_plus), LIST_COUNT_W'(0));
            end
         end
         ST_HEAP_RD: begin
            heap_re = 1'b1;
            heap_raddr = node_ff;
            state_in = ST_HEAP_LD;
         end
         ST_HEAP_LD: begin
            held_in = heap_rdata;
            hole_in = node_ff;
            state_in = ST_SIFT_CHK;
         end
         ST_SIFT_CHK: begin
            if (left_idx < size_ext) begin
               heap_re = 1'b1;
               heap_raddr = left_idx[HAW-1:0];
               state_in = ST_SIFT_LEFT;
            end else begin
               heap_we = 1'b1;
               sift_done = 1'b1;
            end
         end
         ST_SIFT_LEFT: begin
            left_in = heap_rdata;
            if (right_idx < size_ext) begin
               heap_re = 1'b1;
               heap_raddr = right_idx[HAW-1:0];
               state_in = ST_SIFT_RIGHT;
            end else begin
               best_in = heap_rdata;
               best_idx_in = left_idx[HAW-1:0];
               state_in = ST_SIFT_DEC;
            end
         end
         ST_SIFT_RIGHT: begin
            if (goes_before(heap_rdata, left_ff)) begin
               best_in = heap_rdata;
               best_idx_in = right_idx[HAW-1:0];
            end else begin
               best_in = left_ff;
               best_idx_in = left_idx[HAW-1:0];
            end
            state_in = ST_SIFT_DEC;
         end
         ST_SIFT_DEC: begin
            heap_we = 1'b1;
            if (goes_before(best_ff, held_ff)) begin
               // child moves up into the hole
               heap_wdata = best_ff;
               hole_in = best_idx_ff;
               state_in = ST_SIFT_CHK;
            end else begin
               sift_done = 1'b1;
            end
         end
         ST_POP_RD: begin
            heap_re = 1'b1;
            heap_raddr = '0;
            state_in = ST_POP_TOP;
         end
         ST_POP_TOP: begin
            if (out_free) begin
               emit.valid = 1'b1;
               if (top_more) begin
                  elem_re = 1'b1;
                  elem_raddr = elem_addr(heap_rdata.list, top_pos_next);
                  state_in = ST_POP_NEXT;
               end else begin
                  size_in = size_dec;
                  if (size_ff == CW'(1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     heap_re = 1'b1;
                     heap_raddr = size_dec[HAW-1:0];
                     state_in = ST_POP_LAST;
                  end
               end
            end
         end
         ST_POP_NEXT: begin
            held_in.value = elem_rdata;
            held_in.list = heap_rdata.list;
            held_in.pos = heap_rdata.pos + FIELD_W'(1);
            hole_in = '0;
            state_in = ST_SIFT_CHK;
         end
         ST_POP_LAST: begin
            held_in = heap_rdata;
            hole_in = '0;
            state_in = ST_SIFT_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (sift_done) begin
         if (heapify_ff) begin
            if (node_ff == '0) begin
               heapify_in = 1'b0;
               state_in = ST_POP_RD;
            end else begin
               node_in = node_ff - HAW'(1);
               state_in = ST_HEAP_RD;
            end
         end else begin
            state_in = ST_POP_RD;
         end
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result produced while output register is occupied");

   a_heap_write_range: assert property (@(posedge clock) disable iff (reset)
      heap_we |-> (IW'(heap_waddr) < size_ext))
      else $error("heap write beyond the heap size");

   a_last_ends_merge: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.last) |=> (state_ff == ST_IDLE))
      else $error("merge did not finish after the last value");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((size_ff <= k_ff) && (k_ff != '0)))
      else $error("heap size exceeds the list count");

endmodule

>>> bench/tb_top.sv
module tb_top;

   localparam int LISTS = kwsm_pkg::MAX_LISTS_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic command;
      logic [kwsm_pkg::FIELD_W-1:0] list_index;
      logic [kwsm_pkg::FIELD_W-1:0] position;
      logic signed [kwsm_pkg::DATA_W-1:0] value;
   } request_type;

   typedef struct {
      logic signed [kwsm_pkg::DATA_W-1:0] value;
      logic last;
   } merged_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = kwsm_pkg::CMD_LOAD;
   logic [kwsm_pkg::FIELD_W-1:0] req_list_index = '0;
   logic [kwsm_pkg::FIELD_W-1:0] req_position = '0;
   logic signed [kwsm_pkg::DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [kwsm_pkg::DATA_W-1:0] rsp_merged_value;
   logic rsp_last_flag;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [kwsm_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [kwsm_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [kwsm_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   // predicted block state
   logic signed [kwsm_pkg::DATA_W-1:0] element_image [LISTS*LISTS];
   logic [kwsm_pkg::LIST_COUNT_W-1:0] list_count_image = kwsm_pkg::LIST_COUNT_RESET;

   request_type pending_requests[$];
   merged_type merged_due[$];
   bit loaded [LISTS*LISTS];
   int items_sent = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   request_type next_req;
   merged_type want;
   logic req_taken = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   int rsp_stall = 0;
   int rsp_calm = 0;
   int holds_asked = 0;
   int holds_done = 0;

   k_way_sorted_merge u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_list_index   (req_list_index),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last_flag    (rsp_last_flag),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly no gap, some short, a few long, and now and then a calm stretch
   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int lists_in_use();
      return (list_count_image > LISTS) ? LISTS : int'(list_count_image);
   endfunction

   // each list has one head in the heap, so every pop is the smallest head,
   // lower list first on equal values
   function automatic void merge_lists();
      int k;
      int best;
      int head [LISTS];
      merged_type w;
      k = lists_in_use();
      for (int i = 0; i < LISTS; i++) head[i] = 0;
      for (int n = 1; n <= k * k; n++) begin
         best = -1;
         for (int i = 0; i < k; i++) begin
            if (head[i] < k && (best < 0 || element_image[i*LISTS + head[i]] <
                                element_image[best*LISTS + head[best]]))
               best = i;
         end
         w.value = element_image[best*LISTS + head[best]];
         w.last = (n == k * k);
         merged_due.insert(merged_due.size(), w);
         head[best]++;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            req_command <= next_req.command;
            req_list_index <= next_req.list_index;
            req_position <= next_req.position;
            req_value <= next_req.value;
            req_valid <= 1'b1;
            send_gap = draw_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         rsp_stall = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall = draw_gap(rsp_calm);
         rsp_ready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            if (req_command == kwsm_pkg::CMD_MERGE)
               merge_lists();
            else
               element_image[{req_list_index, req_position}] = req_value;
         end
         if (rsp_valid && rsp_ready) begin
            if (merged_due.size() == 0) begin
               $error("result with nothing expected: merged_value %0d last_flag %0b",
                      rsp_merged_value, rsp_last_flag);
               mismatches++;
            end else begin
               want = merged_due.pop_front();
               if (rsp_merged_value !== want.value) begin
                  $error("merged_value: expected %0d, got %0d", want.value, rsp_merged_value);
                  mismatches++;
               end
               if (rsp_last_flag !== want.last) begin
                  $error("last_flag: expected %0b, got %0b", want.last, rsp_last_flag);
                  mismatches++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[k_way_sorted_merge] ERROR");
            $finish;
         end
      end
   end

   task automatic send_req(logic cmd, int li, int pos, logic signed [kwsm_pkg::DATA_W-1:0] v);
      request_type it;
      it.command = cmd;
      it.list_index = li[kwsm_pkg::FIELD_W-1:0];
      it.position = pos[kwsm_pkg::FIELD_W-1:0];
      it.value = v;
      if (cmd == kwsm_pkg::CMD_LOAD)
         loaded[li*LISTS + pos] = 1'b1;
      pending_requests.insert(pending_requests.size(), it);
      items_sent++;
   endtask

   // one ascending list, loaded front to back or back to front
   task automatic send_list(int li, int k, bit upward);
      longint v;
      int style;
      int step_max;
      logic signed [kwsm_pkg::DATA_W-1:0] vals [LISTS];
      style = $urandom_range(0, 2);
      step_max = 2;
      case (style)
         0: v = longint'($urandom_range(0, 6)) - 3;
         1: begin
            v = longint'($signed($urandom));
            step_max = 1 << 28;
         end
         default: v = -64'sd2147483648;
      endcase
      for (int j = 0; j < k; j++) begin
         vals[j] = v[kwsm_pkg::DATA_W-1:0];
         if (style == 2) begin
            if ($urandom_range(0, 1) != 0) v = v + 64'sd4294967295;
         end else begin
            v = v + longint'($urandom_range(0, step_max));
         end
         if (v > 64'sd2147483647) v = 64'sd2147483647;
      end
      for (int j = 0; j < k; j++)
         send_req(kwsm_pkg::CMD_LOAD, li, upward ? j : k - 1 - j, vals[upward ? j : k - 1 - j]);
   endtask

   // a merge may only read loaded elements, so fill any holes first
   task automatic send_merge();
      int k;
      k = lists_in_use();
      for (int i = 0; i < k; i++)
         for (int p = 0; p < k; p++)
            if (!loaded[i*LISTS + p]) send_req(kwsm_pkg::CMD_LOAD, i, p, $urandom);
      send_req(kwsm_pkg::CMD_MERGE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || merged_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_list_count(int k);
      drain();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {kwsm_pkg::REG_LIST_COUNT, 2'b00};
      pwdata <= k;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      list_count_image = k[kwsm_pkg::LIST_COUNT_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int r;
      int k;
      int kind;
      int stop_at;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_list_count(1);
      send_req(kwsm_pkg::CMD_LOAD, 0, 0, 32'sh8000_0000);
      send_merge();
      write_list_count(2);
      // equal heads in both lists
      send_req(kwsm_pkg::CMD_LOAD, 0, 0, -5);
      send_req(kwsm_pkg::CMD_LOAD, 0, 1, 32'sh7FFF_FFFF);
      send_req(kwsm_pkg::CMD_LOAD, 1, 0, -5);
      send_req(kwsm_pkg::CMD_LOAD, 1, 1, 0);
      send_merge();
      // list out of order
      send_req(kwsm_pkg::CMD_LOAD, 1, 0, 100);
      send_req(kwsm_pkg::CMD_LOAD, 1, 1, -100);
      send_merge();
      send_req(kwsm_pkg::CMD_LOAD, 7, 7, 32'sh5555_5555);
      send_req(kwsm_pkg::CMD_LOAD, 7, 7, 32'shAAAA_AAAA);
      write_list_count(0);
      send_merge();
      send_merge();

      // receiver holds off while merges queue up behind it
      write_list_count(4);
      for (int i = 0; i < 4; i++) send_list(i, 4, 1'b1);
      holds_asked++;
      repeat (3) begin
         send_list($urandom_range(0, 3), 4, $urandom_range(0, 1));
         send_merge();
      end

      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 6) k = 0;
         else if (r < 10) k = $urandom_range(9, 15);
         else if (r < 14) k = 8;
         else if (r < 22) k = 1;
         else k = $urandom_range(2, 6);
         write_list_count(k);
         repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               for (int i = 0; i < lists_in_use(); i++)
                  send_list(i, lists_in_use(), $urandom_range(0, 1));
               if ($urandom_range(0, 3) == 0)
                  send_req(kwsm_pkg::CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom);
            end else if (kind >= 85) begin
               repeat ($urandom_range(1, 6))
                  send_req(kwsm_pkg::CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom);
            end
            send_merge();
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("[k_way_sorted_merge] OK");
      end else begin
         $display("[k_way_sorted_merge] ERROR");
      end
      $finish;
   end

endmodule
